/* design/sitoa_pkg.sv */
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int ITER_W     = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0]         CHAR_MINUS   = 6'd45;
    localparam logic [CHAR_W-DIGIT_W-1:0] DIGIT_PREFIX = 2'b11;
    localparam logic [DIGIT_W-1:0]        DIGIT_NINE   = 4'd9;
    localparam logic [DIGIT_W-1:0]        ADJ_LIMIT    = 4'd5;
    localparam logic [DIGIT_W-1:0]        ADJ_ADD      = 4'd3;

endpackage

`default_nettype wire

/* design/signed_int_to_decimal_ascii_unit.sv */
// Converts one signed 32-bit integer into its decimal ASCII text.
// Input channel: i_valid carries a request with i_value; o_stall is high
// while a conversion is in progress, so one number is handled at a time.
// Output channel: o_valid carries the characters of each request on o_character,
// most significant first, with a leading minus sign for negative values and
// o_last set on the final digit. The receiver holds it with i_stall.
// Steps: the magnitude is shifted through a double-dabble unit over all 32
// of its bits, then leading zero digits are dropped at one per cycle, then the
// characters leave at one per cycle (up to 11) while not stalled. Each
// dropped zero is one digit fewer to send. A new request is taken once
// the last character sits in the output register.
// When the receiver stalls, the held character stays on the outputs and
// the emission sequence waits for it.
// A synchronous active-low reset returns the block to idle and drops any
// character that has not been taken.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic signed [sitoa_pkg::VALUE_W-1:0] i_value,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]          o_character,
    output logic                                  o_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state                             r_state, n_state;
    logic [sitoa_pkg::VALUE_W-1:0]      r_bin, n_bin;
    logic [sitoa_pkg::BCD_W-1:0]        r_bcd, n_bcd;
    logic [sitoa_pkg::ITER_W-1:0]       r_iter, n_iter;
    logic [sitoa_pkg::NDIG_W-1:0]       r_ndig, n_ndig;
    logic                               r_neg, n_neg;
    logic                               r_out_valid, n_out_valid;
    logic [sitoa_pkg::CHAR_W-1:0]       r_char, n_char;
    logic                               r_last, n_last;

    logic [sitoa_pkg::BCD_W-1:0]        adj_bcd;
    logic [sitoa_pkg::DIGIT_W-1:0]      top_digit;
    logic                               slot_free;
    logic                               accept;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || !i_stall;
    assign top_digit = r_bcd[sitoa_pkg::BCD_W-1 -: sitoa_pkg::DIGIT_W];

    always_comb begin
        logic [sitoa_pkg::DIGIT_W-1:0] dig;
        for (int k = 0; k < sitoa_pkg::NUM_DIGITS; k++) begin
            dig = r_bcd[k*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W];
            if (dig >= sitoa_pkg::ADJ_LIMIT) begin
                adj_bcd[k*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] = dig + sitoa_pkg::ADJ_ADD;
            end else begin
                adj_bcd[k*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] = dig;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_iter      = r_iter;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_neg   = i_value[sitoa_pkg::VALUE_W-1];
                    n_bin   = i_value[sitoa_pkg::VALUE_W-1] ?
                              (sitoa_pkg::VALUE_W'(0) - sitoa_pkg::VALUE_W'(i_value)) :
                              sitoa_pkg::VALUE_W'(i_value);
                    n_bcd   = '0;
                    n_iter  = '1;
                    n_ndig  = sitoa_pkg::NDIG_W'(sitoa_pkg::NUM_DIGITS);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = {adj_bcd[sitoa_pkg::BCD_W-2:0], r_bin[sitoa_pkg::VALUE_W-1]};
                n_bin  = {r_bin[sitoa_pkg::VALUE_W-2:0], 1'b0};
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((top_digit == '0) && (r_ndig > sitoa_pkg::NDIG_W'(1))) begin
                    n_bcd  = {r_bcd[sitoa_pkg::BCD_W-sitoa_pkg::DIGIT_W-1:0],
                              {sitoa_pkg::DIGIT_W{1'b0}}};
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sitoa_pkg::CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = {sitoa_pkg::DIGIT_PREFIX, top_digit};
                    n_last      = (r_ndig == sitoa_pkg::NDIG_W'(1));
                    n_bcd       = {r_bcd[sitoa_pkg::BCD_W-sitoa_pkg::DIGIT_W-1:0],
                                   {sitoa_pkg::DIGIT_W{1'b0}}};
                    n_ndig      = r_ndig - 1'b1;
                    if (r_ndig == sitoa_pkg::NDIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bin       <= n_bin;
            r_bcd       <= n_bcd;
            r_iter      <= n_iter;
            r_ndig      <= n_ndig;
            r_neg       <= n_neg;
            r_char      <= n_char;
            r_last      <= n_last;
        end
    end

    // A shown character is either the minus sign, which never ends a number,
    // or a decimal digit.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character == sitoa_pkg::CHAR_MINUS) && !o_last) ||
                    ((o_character[sitoa_pkg::CHAR_W-1:sitoa_pkg::DIGIT_W] ==
                      sitoa_pkg::DIGIT_PREFIX) &&
                     (o_character[sitoa_pkg::DIGIT_W-1:0] <= sitoa_pkg::DIGIT_NINE)))
        else $error("illegal character on output");

    // An accepted request always starts the conversion loop.
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_CONV))
        else $error("accepted request did not start conversion");

    // The digit count never runs out while digits are still being dropped or sent.
    a_ndig_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SKIP) || (r_state == ST_SIGN) || (r_state == ST_EMIT)) |->
        ((r_ndig != '0) && (r_ndig <= sitoa_pkg::NDIG_W'(sitoa_pkg::NUM_DIGITS))))
        else $error("digit count out of range");

    // The minus sign is only sent for a negative value.
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> r_neg)
        else $error("sign state entered for a non-negative value");

endmodule

`default_nettype wire
